FILE: design/bfcc_pkg.sv
// ----------------------------------------------------------------------------
// bfcc_pkg: shared types, constants and CRC function for the frame checker
// Holds the result record, status codes, register indexes and the per-byte
// MSB-first CRC-32 update.
// ----------------------------------------------------------------------------
`default_nettype none

package bfcc_pkg;

	// Frame format constants
	localparam int unsigned LengthBits   = 16;
	localparam int unsigned PosBits      = 17;
	localparam int unsigned TrailerBytes = 4;

	localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
	localparam logic [31:0] CrcPoly = 32'h04C1_1DB7;
	localparam logic [15:0] LengthMask = 16'((32'd1 << LengthBits) - 32'd1);
	localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};

	// Configuration register indexes
	localparam logic [1:0] CfgTokenIdx  = 2'd0;
	localparam logic [1:0] CfgUpdateIdx = 2'd1;

	// Result status codes
	typedef enum logic [1:0] {
		StatusOk       = 2'd0,
		StatusBadToken = 2'd1,
		StatusSize     = 2'd2,
		StatusCrc      = 2'd3
	} status_t;

	// One result item
	typedef struct packed {
		status_t     status;
		logic [7:0]  request_code;
		logic [15:0] payload_length;
		logic [31:0] received_crc;
		logic [31:0] computed_crc;
	} result_t;

	// Fold one byte into the CRC: xor into the top byte, then 32 shifts.
	// The shifts collapse into a flat xor network.
	function automatic logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {b, 24'h00_0000};
		for (int k = 0; k < 32; k++) begin
			if (c[31]) begin
				c = {c[30:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[30:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: design/bfcc_in_stage.sv
// ----------------------------------------------------------------------------
// bfcc_in_stage: input register
// Captures one byte item per cycle while in_ready is high and holds it until the frame logic takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bfcc_in_stage
	import bfcc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       frame_end,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      data_s1,
	output logic            end_s1
);

	logic take;

	// Accept whenever the stage is empty or drains this cycle
	assign in_ready = !valid_s1 || advance;
	assign take     = in_valid && in_ready;

	// Track stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Hold the item payload
	always_ff @(posedge clk) begin
		if (take) begin
			data_s1 <= data_byte;
			end_s1  <= frame_end;
		end
	end

endmodule

`default_nettype wire

FILE: design/bfcc_frame_core.sv
// ----------------------------------------------------------------------------
// bfcc_frame_core: frame state and end-of-frame decision
// Tracks position, header fields, the four-byte trailer delay line and the
// running CRC; builds the result on the byte that ends the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module bfcc_frame_core
	import bfcc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       advance,
	input  wire logic [7:0] data_s1,
	input  wire logic       end_s1,
	input  wire logic [7:0] token_value,
	input  wire logic [7:0] update_request_code,
	output logic            res_valid,
	output result_t         res
);

	logic [PosBits-1:0] pos_q, pos_next;
	logic [31:0]        crc_q, crc_next;
	logic [15:0]        len_q, len_next;
	logic [15:0]        first_q, first_next;
	logic [31:0]        tail_q, tail_next, tail_out;

	// Per-byte state update
	always_comb begin
		crc_next   = crc_q;
		len_next   = len_q;
		first_next = first_q;
		if (pos_q >= PosBits'(TrailerBytes)) begin
			crc_next = crc_step(crc_q, tail_q[7:0]);
		end
		tail_next = {data_s1, tail_q[31:8]};
		case (pos_q)
			PosBits'(0): first_next = {8'h00, data_s1};
			PosBits'(1): first_next = {data_s1, first_q[7:0]};
			PosBits'(2): len_next   = {8'h00, data_s1} & LengthMask;
			PosBits'(3): len_next   = (len_q | {data_s1, 8'h00}) & LengthMask;
			default:     ;
		endcase
		pos_next = (pos_q < PosMax) ? pos_q + PosBits'(1) : pos_q;
	end

	// Align a short trailer to the low end
	always_comb begin
		case (pos_next)
			PosBits'(1): tail_out = {24'h00_0000, tail_next[31:24]};
			PosBits'(2): tail_out = {16'h0000, tail_next[31:16]};
			PosBits'(3): tail_out = {8'h00, tail_next[31:8]};
			default:     tail_out = tail_next;
		endcase
	end

	// Decide the frame status
	always_comb begin
		if (pos_next < PosBits'(TrailerBytes)) begin
			res.status = StatusSize;
		end else if (first_next[7:0] != token_value) begin
			res.status = StatusBadToken;
		end else if (first_next[15:8] != update_request_code) begin
			res.status = StatusOk;
		end else if (pos_next != ({1'b0, len_next} + PosBits'(8))) begin
			res.status = StatusSize;
		end else if (tail_out != crc_next) begin
			res.status = StatusCrc;
		end else begin
			res.status = StatusOk;
		end
		res.request_code   = first_next[15:8];
		res.payload_length = len_next;
		res.received_crc   = tail_out;
		res.computed_crc   = crc_next;
	end

	assign res_valid = advance && end_s1;

	// Advance frame state; clear it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			crc_q   <= CrcInit;
			len_q   <= '0;
			first_q <= '0;
			tail_q  <= '0;
		end else if (advance) begin
			if (end_s1) begin
				pos_q   <= '0;
				crc_q   <= CrcInit;
				len_q   <= '0;
				first_q <= '0;
				tail_q  <= '0;
			end else begin
				pos_q   <= pos_next;
				crc_q   <= crc_next;
				len_q   <= len_next;
				first_q <= first_next;
				tail_q  <= tail_next;
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/bfcc_out_stage.sv
// ----------------------------------------------------------------------------
// bfcc_out_stage: result register
// Holds one result item until the consumer takes it; reports when it can load.
// ----------------------------------------------------------------------------
`default_nettype none

module bfcc_out_stage
	import bfcc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire result_t res,
	output logic         slot_free,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      res_q
);

	assign slot_free = !out_valid || out_ready;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

FILE: design/boot_frame_crc_checker.sv
// A byte item held in the input register updates frame state as it advances;
// the result of a frame is loaded into the result register as its last byte does.
// Throughput: one byte item per cycle; the per-byte CRC is one xor network.
// The input stalls only while a final byte waits behind a full result register.
// Reset (arst_n low) empties both stages, zeroes the registers and frame fields
// and sets the running CRC to all ones.
// ----------------------------------------------------------------------------
// boot_frame_crc_checker: request frame checker with CRC-32 trailer
// Checks token, request code, length and CRC of a byte-serial frame.
// ----------------------------------------------------------------------------
`default_nettype none

module boot_frame_crc_checker
	import bfcc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        frame_end,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [7:0]       request_code,
	output logic [15:0]      payload_length,
	output logic [31:0]      received_crc,
	output logic [31:0]      computed_crc
);

	logic [7:0] token_value_q, update_code_q;
	logic       valid_s1, end_s1, advance, slot_free, res_valid;
	logic [7:0] data_s1;
	result_t    res, res_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_value_q <= '0;
			update_code_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgTokenIdx:  token_value_q <= cfg_data;
				CfgUpdateIdx: update_code_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	// Drain the input stage unless a final byte meets a full result register
	assign advance = valid_s1 && (!end_s1 || slot_free);

	bfcc_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.frame_end (frame_end),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.data_s1   (data_s1),
		.end_s1    (end_s1)
	);

	bfcc_frame_core u_core (
		.clk                 (clk),
		.arst_n              (arst_n),
		.advance             (advance),
		.data_s1             (data_s1),
		.end_s1              (end_s1),
		.token_value         (token_value_q),
		.update_request_code (update_code_q),
		.res_valid           (res_valid),
		.res                 (res)
	);

	bfcc_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.res       (res),
		.slot_free (slot_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	// Unpack the result item
	assign status         = res_q.status;
	assign request_code   = res_q.request_code;
	assign payload_length = res_q.payload_length;
	assign received_crc   = res_q.received_crc;
	assign computed_crc   = res_q.computed_crc;

endmodule

`default_nettype wire

FILE: bench/tb_boot_frame_crc_checker.sv
// ----------------------------------------------------------------------------
// tb_boot_frame_crc_checker: self-checking bench for the request frame checker
// Drives byte frames over the valid/ready input while the output side stalls
// at random, predicts each frame verdict (status, header fields, trailer CRC
// and running CRC-32) in a small scoreboard and compares every result field.
// Covers short, bad-token, other-request, size and CRC frames
// across several token and request-code settings.
// ----------------------------------------------------------------------------
module tb_boot_frame_crc_checker;
	import bfcc_pkg::*;

	// Indexes past the two real registers; writes to them must be ignored
	localparam logic [1:0] CfgSpareIdxA = 2'd2;
	localparam logic [1:0] CfgSpareIdxB = 2'd3;
	localparam int PhaseBytes = 225;

	// Scoreboard: tracks frame state and queues the verdict each frame must give
	class frame_verdicts;
		logic [7:0]  token_reg;
		logic [7:0]  update_reg;
		logic [16:0] pos;
		logic [31:0] crc;
		logic [31:0] tail;
		logic [15:0] len;
		logic [15:0] head;
		result_t     verdict_q[$];
		int          errors;

		function new();
			token_reg = 8'h00;
			update_reg = 8'h00;
			errors = 0;
			restart();
		endfunction

		function void restart();
			pos = '0;
			crc = CrcInit;
			tail = '0;
			len = '0;
			head = '0;
		endfunction

		// MSB-first CRC-32: fold the byte into the top, then shift 32 times
		static function logic [31:0] fold_byte(logic [31:0] c, logic [7:0] b);
			logic [31:0] r;
			r = c ^ {b, 24'h0};
			repeat (32) r = r[31] ? ((r << 1) ^ CrcPoly) : (r << 1);
			return r;
		endfunction

		function void write_reg(logic [1:0] idx, logic [7:0] v);
			if (idx == CfgTokenIdx) token_reg = v;
			else if (idx == CfgUpdateIdx) update_reg = v;
		endfunction

		// Advance the frame by one accepted byte; queue a verdict on the last one
		function void take_byte(logic [7:0] b, logic is_last);
			result_t v;
			int n;
			if (pos >= TrailerBytes) crc = fold_byte(crc, tail[7:0]);
			tail = {b, tail[31:8]};
			case (pos)
				17'd0: head = {8'h00, b};
				17'd1: head[15:8] = b;
				17'd2: len = {8'h00, b};
				17'd3: len[15:8] = b;
				default: ;
			endcase
			if (pos != PosMax) pos = pos + 17'd1;
			if (!is_last) return;

			n = int'(pos);
			if (n < TrailerBytes) begin
				// short frame: align the bytes held to the low end
				tail = tail >> (8 * (TrailerBytes - n));
				v.status = StatusSize;
			end else if (head[7:0] != token_reg) begin
				v.status = StatusBadToken;
			end else if (head[15:8] != update_reg) begin
				v.status = StatusOk;
			end else if (n != int'(len) + 8) begin
				v.status = StatusSize;
			end else if (tail != crc) begin
				v.status = StatusCrc;
			end else begin
				v.status = StatusOk;
			end
			v.request_code = head[15:8];
			v.payload_length = len & LengthMask;
			v.received_crc = tail;
			v.computed_crc = crc;
			verdict_q.push_back(v);
			restart();
		endfunction

		function void flag(string what, logic [31:0] want, logic [31:0] got);
			errors++;
			if (errors <= 40)
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
		endfunction

		// Compare one result item with the oldest queued verdict
		function void match_verdict(result_t got);
			result_t want;
			if (verdict_q.size() == 0) begin
				errors++;
				if (errors <= 40)
					$display("%0t: unexpected result, expected none, got status %0d crc %0h",
						$time, got.status, got.computed_crc);
				return;
			end
			want = verdict_q.pop_front();
			if (want.status != got.status) flag("status", want.status, got.status);
			if (want.request_code != got.request_code)
				flag("request_code", want.request_code, got.request_code);
			if (want.payload_length != got.payload_length)
				flag("payload_length", want.payload_length, got.payload_length);
			if (want.received_crc != got.received_crc)
				flag("received_crc", want.received_crc, got.received_crc);
			if (want.computed_crc != got.computed_crc)
				flag("computed_crc", want.computed_crc, got.computed_crc);
		endfunction

		function int pending();
			return verdict_q.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = 2'd0;
	logic [7:0]  cfg_data = 8'h00;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        frame_end = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [7:0]  request_code;
	logic [15:0] payload_length;
	logic [31:0] received_crc;
	logic [31:0] computed_crc;

	frame_verdicts sb;
	result_t       seen;
	logic [7:0]    frame_bytes[$];
	logic [7:0]    token_now = 8'h00;
	logic [7:0]    update_now = 8'h00;
	int            bytes_sent = 0;
	int            gap_pct = 0;
	int            stall_pct = 0;
	int            stall_left = 0;
	bit            quiet = 1'b0;

	boot_frame_crc_checker i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.frame_end     (frame_end),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.request_code  (request_code),
		.payload_length(payload_length),
		.received_crc  (received_crc),
		.computed_crc  (computed_crc)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Guard against a hung handshake
	initial begin
		#30_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Sample both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n && sb != null) begin
			if (in_valid && in_ready) sb.take_byte(data_byte, frame_end);
			if (out_valid && out_ready) begin
				seen.status = status_t'(status);
				seen.request_code = request_code;
				seen.payload_length = payload_length;
				seen.received_crc = received_crc;
				seen.computed_crc = computed_crc;
				sb.match_verdict(seen);
			end
		end
	end

	// Stall the result side in random bursts
	always @(negedge clk) begin
		if (quiet || stall_pct == 0) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			stall_left = $urandom_range(1, 19) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Present one byte item and hold it until accepted
	task automatic send_byte(input logic [7:0] b, input logic is_last);
		in_valid <= 1'b1;
		data_byte <= b;
		frame_end <= is_last;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic hold_off(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_bytes.size(); i++) begin
			if (!quiet && gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
				hold_off($urandom_range(1, 19));
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
		end
		bytes_sent += frame_bytes.size();
	endtask

	// Drop valid and wait until every verdict is out and the pipe is empty
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		sb.write_reg(idx, v);
		@(negedge clk);
	endtask

	task automatic set_registers(input logic [7:0] tok, input logic [7:0] upd,
		input logic [1:0] spare);
		cfg_write(spare, 8'($urandom));
		cfg_write(CfgTokenIdx, tok);
		cfg_write(CfgUpdateIdx, upd);
		cfg_we <= 1'b0;
		@(negedge clk);
		token_now = tok;
		update_now = upd;
	endtask

	// Build a header, body of random bytes and a little-endian CRC trailer
	task automatic compose_frame(input logic [7:0] tok, input logic [7:0] req,
		input logic [15:0] len_field, input int body_n, input bit bad_crc);
		logic [31:0] c;
		frame_bytes.delete();
		frame_bytes.push_back(tok);
		frame_bytes.push_back(req);
		frame_bytes.push_back(len_field[7:0]);
		frame_bytes.push_back(len_field[15:8]);
		repeat (body_n) frame_bytes.push_back(8'($urandom));
		c = CrcInit;
		foreach (frame_bytes[k]) c = frame_verdicts::fold_byte(c, frame_bytes[k]);
		if (bad_crc) c ^= 32'd1 << $urandom_range(0, 31);
		for (int k = 0; k < 4; k++) frame_bytes.push_back(c[8*k +: 8]);
	endtask

	task automatic raw_frame(input int n);
		frame_bytes.delete();
		repeat (n) frame_bytes.push_back(8'($urandom));
	endtask

	// Mostly well-formed frames with random content, plus broken ones
	task automatic random_frame();
		int kind;
		int len_n;
		int body_n;
		logic [7:0] tok;
		logic [7:0] req;
		kind = $urandom_range(0, 99);
		len_n = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24);
		body_n = len_n;
		tok = token_now;
		req = update_now;
		if ($urandom_range(0, 3) == 0) begin
			gap_pct = 0;
			stall_pct = 0;
		end else begin
			gap_pct = $urandom_range(5, 30);
			stall_pct = $urandom_range(5, 30);
		end
		if (kind < 6) begin
			raw_frame($urandom_range(1, 3));
		end else if (kind < 12) begin
			raw_frame($urandom_range(4, 20));
		end else begin
			if (kind < 22) begin
				// length field disagrees with the bytes that follow
				if ($urandom_range(0, 1) == 1 || len_n < 3) body_n = len_n + $urandom_range(1, 3);
				else body_n = len_n - $urandom_range(1, 3);
			end else if (kind < 29) begin
				tok = token_now ^ 8'($urandom_range(1, 255));
			end else if (kind < 35) begin
				req = update_now ^ 8'($urandom_range(1, 255));
			end
			compose_frame(tok, req, 16'(len_n), body_n, kind >= 35 && $urandom_range(0, 3) == 0);
		end
		send_frame();
	endtask

	initial begin
		int phase_end;
		logic [7:0] tok;
		logic [7:0] upd;
		sb = new();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed frames against the reset register values
		gap_pct = 15;
		stall_pct = 15;
		frame_bytes = '{8'hFF};
		send_frame();
		frame_bytes = '{8'h00, 8'hFF, 8'h80};
		send_frame();
		frame_bytes = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF};
		send_frame();
		frame_bytes = '{8'h00, 8'h7F, 8'h00, 8'h00};
		send_frame();
		compose_frame(8'h00, 8'h00, 16'h0000, 0, 1'b0);
		send_frame();
		compose_frame(8'h00, 8'h00, 16'h0000, 0, 1'b1);
		send_frame();
		wait_idle();

		// Random phases, each under its own register setting
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin tok = 8'hFF; upd = 8'hFF; end
				1: begin tok = 8'h00; upd = 8'hFF; end
				2: begin tok = 8'hFF; upd = 8'h00; end
				default: begin tok = 8'($urandom); upd = 8'($urandom); end
			endcase
			set_registers(tok, upd, ph[0] ? CfgSpareIdxB : CfgSpareIdxA);
			quiet = (ph == 5);
			phase_end = bytes_sent + PhaseBytes;
			while (bytes_sent < phase_end) random_frame();
			wait_idle();
		end

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: files.f
design/bfcc_pkg.sv
design/bfcc_in_stage.sv
design/bfcc_frame_core.sv
design/bfcc_out_stage.sv
design/boot_frame_crc_checker.sv
bench/tb_boot_frame_crc_checker.sv
